@@ rtl/core/gdr_pkg.sv @@
// Shared types, constants and calendar helpers for the Gregorian date register.
// No dependencies; compiled first.

package gdr_pkg;

    localparam int OP_W    = 3;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int WDAY_W  = 3;

    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;

    localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST    = 5'd31;
    localparam logic [DAY_W-1:0]   DAY_LEAP    = 5'd29;
    localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;

    localparam logic [WDAY_W-1:0]  WDAY_SUNDAY = 3'd6;

    // Divisibility by 25: multiply by the inverse of 25 mod 2^14,
    // multiples of 25 land on 0..floor((2^14-1)/25).
    localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

    // y / 100 = (y * 10486) >> 20, exact for y < 2^14
    localparam int                DIV100_SHIFT = 20;
    localparam logic [YEAR_W-1:0] DIV100_MUL   = 14'd10486;
    localparam int                Q100_W       = 8;

    // s mod 7 via s / 7 = (s * 18725) >> 17, exact for s < 2^15
    localparam int          SUM_W      = 15;
    localparam int          MOD7_SHIFT = 17;
    localparam logic [14:0] MOD7_MUL   = 15'd18725;
    localparam int          Q7_W       = 12;

    typedef enum logic [OP_W-1:0] {
        OP_SET        = 3'd0,
        OP_NEXT_DAY   = 3'd1,
        OP_PREV_DAY   = 3'd2,
        OP_NEXT_MONTH = 3'd3,
        OP_NEXT_YEAR  = 3'd4,
        OP_READ       = 3'd5
    } op_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    // 4/100/400 rule; year 0 is a leap year
    function automatic logic leap_of(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] p;
        logic              div25;
        p     = YEAR_W'(y * INV25);
        div25 = (p <= DIV25_MAX);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:2] == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

    // Month offset for the weekday sum; Jan and Feb differ in leap years
    function automatic logic [2:0] wk_off(input logic [MONTH_W-1:0] m,
                                          input logic leap);
        logic [2:0] o;
        case (m)
            4'd1:    o = leap ? 3'd6 : 3'd0;
            4'd2:    o = leap ? 3'd2 : 3'd3;
            4'd3:    o = 3'd3;
            4'd4:    o = 3'd6;
            4'd5:    o = 3'd1;
            4'd6:    o = 3'd4;
            4'd7:    o = 3'd6;
            4'd8:    o = 3'd2;
            4'd9:    o = 3'd5;
            4'd10:   o = 3'd0;
            4'd11:   o = 3'd3;
            4'd12:   o = 3'd5;
            default: o = 3'd0;
        endcase
        return o;
    endfunction

endpackage

@@ rtl/core/gdr_cmd_if.sv @@
// Command channel: valid/ready handshake with the command beat.
// Depends on gdr_pkg.

interface gdr_cmd_if;
    import gdr_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [DAY_W-1:0]   set_day;
    logic [MONTH_W-1:0] set_month;
    logic [YEAR_W-1:0]  set_year;

    modport source (output valid, opcode, set_day, set_month, set_year, input ready);
    modport sink   (input valid, opcode, set_day, set_month, set_year, output ready);
endinterface

@@ rtl/core/gdr_res_if.sv @@
// Result channel: valid/ready handshake with the date, weekday and flags.
// Depends on gdr_pkg.

interface gdr_res_if;
    import gdr_pkg::*;

    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   day_now;
    logic [MONTH_W-1:0] month_now;
    logic [YEAR_W-1:0]  year_now;
    logic [WDAY_W-1:0]  weekday;
    logic               is_leap;
    logic               accepted;

    modport source (output valid, day_now, month_now, year_now, weekday, is_leap, accepted,
                    input ready);
    modport sink   (input valid, day_now, month_now, year_now, weekday, is_leap, accepted,
                    output ready);
endinterface

@@ rtl/core/gdr_update.sv @@
// Next-date logic: applies one command to the stored date.
// Depends on gdr_pkg.

module gdr_update (
    input  gdr_pkg::date_t               cur,
    input  logic [gdr_pkg::OP_W-1:0]     opcode,
    input  logic [gdr_pkg::DAY_W-1:0]    set_day,
    input  logic [gdr_pkg::MONTH_W-1:0]  set_month,
    input  logic [gdr_pkg::YEAR_W-1:0]   set_year,
    output gdr_pkg::date_t               nxt,
    output logic                         ok
);
    import gdr_pkg::*;

    logic               leap_cur;
    logic               leap_inc;
    logic               leap_set;
    logic [DAY_W-1:0]   dim_cur;
    logic [DAY_W-1:0]   dim_prev;
    logic [DAY_W-1:0]   dim_m1;
    logic [DAY_W-1:0]   dim_set;
    logic [MONTH_W-1:0] month_inc;
    logic [MONTH_W-1:0] month_dec;
    logic [YEAR_W-1:0]  year_inc;
    logic [YEAR_W-1:0]  year_dec;

    // leap flags and month lengths
    always_comb
    begin
        month_inc = MONTH_W'(cur.month + 4'd1);
        month_dec = MONTH_W'(cur.month - 4'd1);
        year_inc  = YEAR_W'(cur.year + 14'd1);
        year_dec  = YEAR_W'(cur.year - 14'd1);
        leap_cur  = leap_of(cur.year);
        leap_inc  = leap_of(year_inc);
        leap_set  = leap_of(set_year);
        dim_cur   = days_in(cur.month, leap_cur);
        dim_prev  = days_in(month_dec, leap_cur);
        dim_m1    = days_in(month_inc, leap_cur);
        dim_set   = days_in(set_month, leap_set);
    end

    // command decode
    always_comb
    begin
        nxt = cur;
        ok  = 1'b0;
        case (opcode)
            OP_SET:
            begin
                if ((set_month >= MONTH_JAN) && (set_month <= MONTH_DEC) &&
                    (set_year <= YEAR_MAX) && (set_day >= DAY_FIRST) &&
                    (set_day <= dim_set))
                begin
                    nxt.day   = set_day;
                    nxt.month = set_month;
                    nxt.year  = set_year;
                    ok        = 1'b1;
                end
            end
            OP_NEXT_DAY:
            begin
                if (cur.day < dim_cur)
                begin
                    nxt.day = DAY_W'(cur.day + 5'd1);
                    ok      = 1'b1;
                end
                else if (cur.month < MONTH_DEC)
                begin
                    nxt.day   = DAY_FIRST;
                    nxt.month = month_inc;
                    ok        = 1'b1;
                end
                else if (cur.year < YEAR_MAX)
                begin
                    nxt.day   = DAY_FIRST;
                    nxt.month = MONTH_JAN;
                    nxt.year  = year_inc;
                    ok        = 1'b1;
                end
            end
            OP_PREV_DAY:
            begin
                if (cur.day > DAY_FIRST)
                begin
                    nxt.day = DAY_W'(cur.day - 5'd1);
                    ok      = 1'b1;
                end
                else if (cur.month > MONTH_JAN)
                begin
                    nxt.month = month_dec;
                    nxt.day   = dim_prev;
                    ok        = 1'b1;
                end
                else if (cur.year != '0)
                begin
                    nxt.year  = year_dec;
                    nxt.month = MONTH_DEC;
                    nxt.day   = DAY_LAST;
                    ok        = 1'b1;
                end
            end
            OP_NEXT_MONTH:
            begin
                // short months are never adjacent: at most one skip
                if (cur.month < MONTH_DEC)
                begin
                    if ((month_inc < MONTH_DEC) && (cur.day > dim_m1))
                        nxt.month = MONTH_W'(month_inc + 4'd1);
                    else
                        nxt.month = month_inc;
                    ok = 1'b1;
                end
                else if (cur.year < YEAR_MAX)
                begin
                    nxt.month = MONTH_JAN;
                    nxt.year  = year_inc;
                    ok        = 1'b1;
                end
            end
            OP_NEXT_YEAR:
            begin
                if ((cur.year < YEAR_MAX) &&
                    !((cur.month == MONTH_FEB) && (cur.day == DAY_LEAP) && !leap_inc))
                begin
                    nxt.year = year_inc;
                    ok       = 1'b1;
                end
            end
            OP_READ:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/gdr_weekday.sv @@
// Result pipeline: weekday and leap flag of the updated date, three elastic
// stages plus the result register. Depends on gdr_pkg and gdr_res_if.

module gdr_weekday (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  gdr_pkg::date_t  in_date,
    input  logic            in_ok,
    gdr_res_if.source       res
);
    import gdr_pkg::*;

    // stage a: snapshot of the date after the command
    logic        a_valid_reg;
    date_t       a_date_reg;
    logic        a_ok_reg;
    // stage b: century quotient and leap flag
    logic        b_valid_reg;
    date_t       b_date_reg;
    logic        b_ok_reg;
    logic        b_leap_reg;
    logic [Q100_W-1:0] b_q100_reg;
    // stage c: weekday sum
    logic        c_valid_reg;
    date_t       c_date_reg;
    logic        c_ok_reg;
    logic        c_leap_reg;
    logic [SUM_W-1:0] c_sum_reg;
    // result register
    logic        o_valid_reg;
    date_t       o_date_reg;
    logic        o_ok_reg;
    logic        o_leap_reg;
    logic [WDAY_W-1:0] o_wday_reg;

    logic        a_free;
    logic        b_free;
    logic        c_free;
    logic        o_free;

    logic [27:0]       prod100;
    logic [Q100_W-1:0] q100;
    logic              leap_a;
    logic [SUM_W-1:0]  sum_b;
    logic [29:0]       prod7;
    logic [Q7_W-1:0]   q7;
    logic [WDAY_W-1:0] rem7;
    logic [WDAY_W-1:0] wday_c;

    // backpressure chain: a stage takes a beat when it is empty or drains
    assign o_free   = !o_valid_reg || res.ready;
    assign c_free   = !c_valid_reg || o_free;
    assign b_free   = !b_valid_reg || c_free;
    assign a_free   = !a_valid_reg || b_free;
    assign in_ready = a_free;

    // stage b logic: y / 100 by reciprocal multiply, leap rule
    always_comb
    begin
        prod100 = 28'(a_date_reg.year) * 28'(DIV100_MUL);
        q100    = prod100[DIV100_SHIFT +: Q100_W];
        leap_a  = leap_of(a_date_reg.year);
    end

    // stage c logic: y + y/4 - y/100 + y/400 + d + offset - 1
    always_comb
    begin
        sum_b = SUM_W'(b_date_reg.year) + SUM_W'(b_date_reg.year >> 2)
              - SUM_W'(b_q100_reg) + SUM_W'(b_q100_reg >> 2)
              + SUM_W'(b_date_reg.day) + SUM_W'(wk_off(b_date_reg.month, b_leap_reg))
              - SUM_W'(1);
    end

    // result logic: sum mod 7, then Sunday-first to Monday-first
    always_comb
    begin
        prod7  = 30'(c_sum_reg) * 30'(MOD7_MUL);
        q7     = prod7[MOD7_SHIFT +: Q7_W];
        rem7   = WDAY_W'(c_sum_reg - SUM_W'(q7) * SUM_W'(7));
        wday_c = (rem7 == '0) ? WDAY_SUNDAY : WDAY_W'(rem7 - 3'd1);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free) a_valid_reg <= in_valid;
            if (b_free) b_valid_reg <= a_valid_reg;
            if (c_free) c_valid_reg <= b_valid_reg;
            if (o_free) o_valid_reg <= c_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (a_free && in_valid)
        begin
            a_date_reg <= in_date;
            a_ok_reg   <= in_ok;
        end
        if (b_free && a_valid_reg)
        begin
            b_date_reg <= a_date_reg;
            b_ok_reg   <= a_ok_reg;
            b_leap_reg <= leap_a;
            b_q100_reg <= q100;
        end
        if (c_free && b_valid_reg)
        begin
            c_date_reg <= b_date_reg;
            c_ok_reg   <= b_ok_reg;
            c_leap_reg <= b_leap_reg;
            c_sum_reg  <= sum_b;
        end
        if (o_free && c_valid_reg)
        begin
            o_date_reg <= c_date_reg;
            o_ok_reg   <= c_ok_reg;
            o_leap_reg <= c_leap_reg;
            o_wday_reg <= wday_c;
        end
    end

    assign res.valid     = o_valid_reg;
    assign res.day_now   = o_date_reg.day;
    assign res.month_now = o_date_reg.month;
    assign res.year_now  = o_date_reg.year;
    assign res.weekday   = o_wday_reg;
    assign res.is_leap   = o_leap_reg;
    assign res.accepted  = o_ok_reg;

endmodule

@@ rtl/core/gregorian_date_register.sv @@
// Top level of the Gregorian date register: stored date, command update and
// result pipeline. Depends on gdr_pkg, gdr_cmd_if, gdr_res_if, gdr_update, gdr_weekday.
//
//  channel | dir | beat contents
//  --------+-----+--------------------------------------------------------------
//  cmd     | in  | opcode, set_day, set_month, set_year
//  res     | out | day_now, month_now, year_now, weekday, is_leap, accepted
//
// One command per cycle while cmd.ready is high; the date register updates at
// the command beat. Its result passes through stages a, b and c and the result
// register of the weekday path (constant multiplies spread over the stages).
// Reset puts the date at 1 Jan 2000 and empties the pipeline.
// A stalled result holds; the stages behind it keep filling, and cmd.ready
// drops only once all four stages hold a beat.

module gregorian_date_register (
    input  logic      clk,
    input  logic      rst_n,
    gdr_cmd_if.sink   cmd,
    gdr_res_if.source res
);
    import gdr_pkg::*;

    date_t date_reg;
    date_t date_next;
    date_t upd_date;
    logic  upd_ok;
    logic  pipe_ready;
    logic  cmd_beat;

    assign cmd.ready = pipe_ready;
    assign cmd_beat  = cmd.valid && pipe_ready;

    gdr_update u_update (
        .cur       (date_reg),
        .opcode    (cmd.opcode),
        .set_day   (cmd.set_day),
        .set_month (cmd.set_month),
        .set_year  (cmd.set_year),
        .nxt       (upd_date),
        .ok        (upd_ok)
    );

    // stored date
    always_comb
    begin
        date_next = cmd_beat ? upd_date : date_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg.day   <= RESET_DAY;
            date_reg.month <= RESET_MONTH;
            date_reg.year  <= RESET_YEAR;
        end
        else
        begin
            date_reg <= date_next;
        end
    end

    gdr_weekday u_weekday (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (pipe_ready),
        .in_date  (upd_date),
        .in_ok    (upd_ok),
        .res      (res)
    );

endmodule

@@ rtl/core/gdr_checker.sv @@
// Port-level checks for the Gregorian date register, bound to the top level.
// Depends on gdr_pkg and gregorian_date_register.

module gdr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [gdr_pkg::DAY_W-1:0]    day_now,
    input logic [gdr_pkg::MONTH_W-1:0]  month_now,
    input logic [gdr_pkg::YEAR_W-1:0]   year_now,
    input logic [gdr_pkg::WDAY_W-1:0]   weekday,
    input logic                         is_leap,
    input logic                         accepted
);
    import gdr_pkg::*;

    logic [DAY_W-1:0]   last_day_reg;
    logic [MONTH_W-1:0] last_month_reg;
    logic [YEAR_W-1:0]  last_year_reg;
    logic               res_beat;

    assign res_beat = res_valid && res_ready;

    // date of the last delivered beat, i.e. the date before the next command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_day_reg   <= RESET_DAY;
            last_month_reg <= RESET_MONTH;
            last_year_reg  <= RESET_YEAR;
        end
        else if (res_beat)
        begin
            last_day_reg   <= day_now;
            last_month_reg <= month_now;
            last_year_reg  <= year_now;
        end
    end

    // commands back up only behind a stalled result
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> (res_valid && !res_ready))
        else $error("cmd.ready low without a stalled result");

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid &&
            $stable({day_now, month_now, year_now, weekday, is_leap, accepted})))
        else $error("result changed while stalled");

    // rejected command leaves the date of the previous beat
    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !accepted) |->
            ((day_now == last_day_reg) && (month_now == last_month_reg) &&
             (year_now == last_year_reg)))
        else $error("rejected command changed the date");

    // leap flag agrees with the reported year
    a_leap_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (is_leap == leap_of(year_now)))
        else $error("leap flag disagrees with year");

endmodule

bind gregorian_date_register gdr_checker u_gdr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .day_now   (res.day_now),
    .month_now (res.month_now),
    .year_now  (res.year_now),
    .weekday   (res.weekday),
    .is_leap   (res.is_leap),
    .accepted  (res.accepted)
);
